// File: rtl/pcbf_pkg.sv
// Shared types, constants and fixed-point helpers for the planar beam force unit.
// Depends on nothing; used by planar_cosserat_beam_force_unit.
package pcbf_pkg;

	localparam int Width       = 32;
	localparam int CordicSteps = 16;
	localparam int CordicWidth = 34;

	localparam logic [32:0] TurnScale    = 33'd2734261102;
	localparam logic signed [CordicWidth-1:0] CordicGainInv = 34'sd652032874;

	typedef logic signed [Width-1:0]       word_t;
	typedef logic signed [CordicWidth-1:0] cword_t;

	typedef enum logic [2:0] {
		REG_AXIAL_STIFFNESS = 3'd0,
		REG_SHEAR_STIFFNESS = 3'd1,
		REG_ELEMENT_LENGTH  = 3'd2,
		REG_INVERSE_LENGTH  = 3'd3,
		REG_HALF_WEIGHT_X   = 3'd4,
		REG_HALF_WEIGHT_Y   = 3'd5,
		REG_DAMPING_AXIAL   = 3'd6,
		REG_DAMPING_SHEAR   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		word_t dx;
		word_t dy;
		word_t dvx;
		word_t dvy;
		word_t omega;
	} geo_t;

	localparam cword_t AtanTurns [CordicSteps] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
	};

	function automatic word_t sat(input logic signed [65:0] v);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (v > hi)
			return word_t'(hi);
		else if (v < lo)
			return word_t'(lo);
		else
			return word_t'(v);
	endfunction

	function automatic word_t qmul(input word_t a, input word_t b);
		logic signed [65:0] p;
		p = 66'(a) * 66'(b);
		return sat((p + 66'sd32768) >>> 16);
	endfunction

	function automatic word_t qdot(input word_t a1, input word_t b1,
			input word_t a2, input word_t b2);
		logic signed [65:0] p;
		p = 66'(a1) * 66'(b1) + 66'(a2) * 66'(b2);
		return sat((p + 66'sd32768) >>> 16);
	endfunction

	function automatic word_t sub_sat(input word_t a, input word_t b);
		return sat(66'(a) - 66'(b));
	endfunction

	function automatic word_t add_sat(input word_t a, input word_t b);
		return sat(66'(a) + 66'(b));
	endfunction

endpackage

// File: rtl/planar_cosserat_beam_force_unit.sv
// Pipelined generalized force kernel of a planar two-node Cosserat beam element.
// Uses pcbf_pkg for types, the arctangent table and saturating Q16.16 helpers.
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata: 10 x 32-bit positions and velocities
// m_*       out  m_tvalid / m_tready    m_tdata: 5 x 32-bit forces
// cfg_*     in   cfg_valid / cfg_ready  cfg_index (3 bit), cfg_data (32 bit)
//
// One element enters per cycle unless m_tready stalls. Stages: input, 17 CORDIC stages,
// sine/cosine fix-up, six arithmetic stages (all but the last with one multiply level).
// Reset clears valid bits and loads register defaults. A stall on m_tready
// holds every stage at once; nothing is lost or repeated.
module planar_cosserat_beam_force_unit
	import pcbf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// node_a_x, node_a_y, section_angle, node_b_x, node_b_y,
	// node_a_vx, node_a_vy, angle_rate, node_b_vx, node_b_vy
	input  logic [319:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// force_a_x, force_a_y, moment_angle, force_b_x, force_b_y
	output logic [159:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int NumStages = 25;

	logic [30:0] axial_q, shear_q, len_q, ilen_q, damp_a_q, damp_s_q;
	word_t       hwx_q, hwy_q;
	word_t       ea, ga, l0, il, ca, cs;
	logic        en;
	logic [NumStages-1:0] v_q;

	assign cfg_ready = 1'b1;
	assign en        = !v_q[NumStages-1] || m_tready;
	assign s_tready  = en;
	assign m_tvalid  = v_q[NumStages-1];

	assign ea = word_t'({1'b0, axial_q});
	assign ga = word_t'({1'b0, shear_q});
	assign l0 = word_t'({1'b0, len_q});
	assign il = word_t'({1'b0, ilen_q});
	assign ca = word_t'({1'b0, damp_a_q});
	assign cs = word_t'({1'b0, damp_s_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axial_q  <= 31'd65536;
			shear_q  <= 31'd65536;
			len_q    <= 31'd65536;
			ilen_q   <= 31'd65536;
			hwx_q    <= '0;
			hwy_q    <= '0;
			damp_a_q <= '0;
			damp_s_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_AXIAL_STIFFNESS: axial_q  <= cfg_data[30:0];
				REG_SHEAR_STIFFNESS: shear_q  <= cfg_data[30:0];
				REG_ELEMENT_LENGTH:  len_q    <= cfg_data[30:0];
				REG_INVERSE_LENGTH:  ilen_q   <= cfg_data[30:0];
				REG_HALF_WEIGHT_X:   hwx_q    <= cfg_data;
				REG_HALF_WEIGHT_Y:   hwy_q    <= cfg_data;
				REG_DAMPING_AXIAL:   damp_a_q <= cfg_data[30:0];
				REG_DAMPING_SHEAR:   damp_s_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (en)
			v_q <= {v_q[NumStages-2:0], s_tvalid};
	end

	// stage 1: differences and turn fraction
	geo_t        geo_s1;
	logic [31:0] phase_s1;
	logic signed [64:0] turn_prod;

	assign turn_prod = 65'($signed(s_tdata[95:64])) * 65'($signed({1'b0, TurnScale}));

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s1.dx    <= sub_sat(s_tdata[127:96], s_tdata[31:0]);
			geo_s1.dy    <= sub_sat(s_tdata[159:128], s_tdata[63:32]);
			geo_s1.dvx   <= sub_sat(s_tdata[287:256], s_tdata[191:160]);
			geo_s1.dvy   <= sub_sat(s_tdata[319:288], s_tdata[223:192]);
			geo_s1.omega <= s_tdata[255:224];
			phase_s1     <= turn_prod[49:18];
		end
	end

	// CORDIC: entry 0 is the seed, entry k+1 follows step k
	cword_t      cx_s [CordicSteps+1];
	cword_t      cy_s [CordicSteps+1];
	cword_t      cz_s [CordicSteps+1];
	logic [1:0]  quad_s [CordicSteps+1];
	geo_t        geo_c_s [CordicSteps+1];
	logic [31:0] shifted;

	assign shifted = phase_s1 + 32'h2000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0]    <= CordicGainInv;
			cy_s[0]    <= '0;
			cz_s[0]    <= cword_t'({4'b0, shifted[29:0]}) - 34'sh2000_0000;
			quad_s[0]  <= shifted[31:30];
			geo_c_s[0] <= geo_s1;
		end
	end

	for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz_s[k][CordicWidth-1]) begin
					cx_s[k+1] <= cx_s[k] - (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] + (cx_s[k] >>> k);
					cz_s[k+1] <= cz_s[k] - AtanTurns[k];
				end else begin
					cx_s[k+1] <= cx_s[k] + (cy_s[k] >>> k);
					cy_s[k+1] <= cy_s[k] - (cx_s[k] >>> k);
					cz_s[k+1] <= cz_s[k] + AtanTurns[k];
				end
				quad_s[k+1]  <= quad_s[k];
				geo_c_s[k+1] <= geo_c_s[k];
			end
		end
	end

	// sine/cosine rounding and quadrant turn
	cword_t cr, sr;
	word_t  c0, s0, cos_n, sin_n;
	word_t  cos_s19, sin_s19;
	geo_t   geo_s19;

	assign cr = (cx_s[CordicSteps] + 34'sd8192) >>> 14;
	assign sr = (cy_s[CordicSteps] + 34'sd8192) >>> 14;
	assign c0 = word_t'(cr);
	assign s0 = word_t'(sr);

	always_comb begin
		case (quad_s[CordicSteps])
			2'd0: begin cos_n = c0;  sin_n = s0;  end
			2'd1: begin cos_n = -s0; sin_n = c0;  end
			2'd2: begin cos_n = -c0; sin_n = -s0; end
			default: begin cos_n = s0; sin_n = -c0; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s19 <= cos_n;
			sin_s19 <= sin_n;
			geo_s19 <= geo_c_s[CordicSteps];
		end
	end

	// projections
	word_t td_s20, nd_s20, tv_s20, nv_s20, om_s20, cos_s20, sin_s20;

	always_ff @(posedge clk) begin
		if (en) begin
			td_s20  <= qdot(cos_s19, geo_s19.dx, sin_s19, geo_s19.dy);
			nd_s20  <= qdot(-sin_s19, geo_s19.dx, cos_s19, geo_s19.dy);
			tv_s20  <= qdot(cos_s19, geo_s19.dvx, sin_s19, geo_s19.dvy);
			nv_s20  <= qdot(-sin_s19, geo_s19.dvx, cos_s19, geo_s19.dvy);
			om_s20  <= geo_s19.omega;
			cos_s20 <= cos_s19;
			sin_s20 <= sin_s19;
		end
	end

	// stiffness and rate scaling
	word_t a_s21, b_s21, tvil_s21, nvil_s21, om_s21, td_s21, nd_s21, cos_s21, sin_s21;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s21    <= qmul(ea, sub_sat(td_s20, l0));
			b_s21    <= qmul(ga, nd_s20);
			tvil_s21 <= qmul(tv_s20, il);
			nvil_s21 <= qmul(nv_s20, il);
			om_s21   <= om_s20;
			td_s21   <= td_s20;
			nd_s21   <= nd_s20;
			cos_s21  <= cos_s20;
			sin_s21  <= sin_s20;
		end
	end

	// strain forces and damping products
	word_t ft_s22, fn_s22, dt0_s22, dn0_s22, td_s22, nd_s22, cos_s22, sin_s22;

	always_ff @(posedge clk) begin
		if (en) begin
			ft_s22  <= qmul(a_s21, il);
			fn_s22  <= qmul(b_s21, il);
			dt0_s22 <= qmul(ca, tvil_s21);
			dn0_s22 <= qmul(cs, sub_sat(nvil_s21, om_s21));
			td_s22  <= td_s21;
			nd_s22  <= nd_s21;
			cos_s22 <= cos_s21;
			sin_s22 <= sin_s21;
		end
	end

	// section totals and moment terms
	word_t dt2, dn2;
	word_t tt_s23, nn_s23, dn_s23, m1_s23, m2_s23, cos_s23, sin_s23;

	assign dt2 = sat(66'(dt0_s22) <<< 1);
	assign dn2 = sat(66'(dn0_s22) <<< 1);

	always_ff @(posedge clk) begin
		if (en) begin
			tt_s23  <= add_sat(ft_s22, dt2);
			nn_s23  <= add_sat(fn_s22, dn2);
			dn_s23  <= dn2;
			m1_s23  <= qmul(nd_s22, ft_s22);
			m2_s23  <= qmul(td_s22, fn_s22);
			cos_s23 <= cos_s22;
			sin_s23 <= sin_s22;
		end
	end

	// back to global frame
	word_t px_s24, py_s24, m1_s24, m2_s24, m3_s24;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s24 <= qdot(cos_s23, tt_s23, -sin_s23, nn_s23);
			py_s24 <= qdot(sin_s23, tt_s23, cos_s23, nn_s23);
			m1_s24 <= m1_s23;
			m2_s24 <= m2_s23;
			m3_s24 <= qmul(l0, dn_s23);
		end
	end

	// output register
	word_t fax_s25, fay_s25, mom_s25, fbx_s25, fby_s25;

	always_ff @(posedge clk) begin
		if (en) begin
			fax_s25 <= sat(66'(px_s24) + 66'(hwx_q));
			fay_s25 <= sat(66'(py_s24) + 66'(hwy_q));
			mom_s25 <= sat(66'(m2_s24) - 66'(m1_s24) + 66'(m3_s24));
			fbx_s25 <= sat(66'(hwx_q) - 66'(px_s24));
			fby_s25 <= sat(66'(hwy_q) - 66'(py_s24));
		end
	end

	assign m_tdata = {fby_s25, fbx_s25, mom_s25, fay_s25, fax_s25};

endmodule

// File: sim/planar_cosserat_beam_force_unit_tb.sv
// Testbench for planar_cosserat_beam_force_unit: streams beam elements, predicts the forces
// in Q16.16 and compares every output field. Depends on rtl/pcbf_pkg.sv for types and codes.
module planar_cosserat_beam_force_unit_tb;
	import pcbf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Latency = 25;
	localparam longint CycleLimit = 400000;

	typedef logic signed [Width-1:0] elem_t [10];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [319:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [159:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	int err_count = 0;
	longint cycle = 0;
	logic [159:0] force_queue [$];

	logic signed [63:0] axial_k, shear_k, len0, inv_len, hw_x, hw_y, damp_t, damp_n;

	planar_cosserat_beam_force_unit i_dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic signed [63:0] clamp(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		return clamp((a * b + 64'sd32768) >>> 16);
	endfunction

	function automatic logic signed [63:0] fx_dot(input logic signed [63:0] a1,
			input logic signed [63:0] b1, input logic signed [63:0] a2,
			input logic signed [63:0] b2);
		return clamp((a1 * b1 + a2 * b2 + 64'sd32768) >>> 16);
	endfunction

	task automatic angle_to_cos_sin(input logic signed [31:0] ang,
			output logic signed [63:0] cs, output logic signed [63:0] sn);
		logic signed [63:0] atan_tab [16];
		logic [63:0] prod;
		logic [31:0] phase;
		logic [1:0] quad;
		logic signed [63:0] x, y, z, xs, ys, c, s;
		atan_tab = '{64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
			64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
			64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772,
			64'sd166886, 64'sd83443, 64'sd41722, 64'sd20861};
		prod = 64'($signed(ang)) * 64'sd2734261102;
		phase = prod[49:18] + 32'h2000_0000;
		quad = phase[31:30];
		z = $signed({34'd0, phase[29:0]}) - 64'sd536870912;
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - atan_tab[i];
			end else begin
				x = x + ys; y = y - xs; z = z + atan_tab[i];
			end
		end
		c = (x + 64'sd8192) >>> 14;
		s = (y + 64'sd8192) >>> 14;
		case (quad)
			2'd0: begin cs = c; sn = s; end
			2'd1: begin cs = -s; sn = c; end
			2'd2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endtask

	task automatic predict_forces(input elem_t e, output logic [159:0] f);
		logic signed [63:0] c, s, dx, dy, dvx, dvy, td, nd, tv, nv;
		logic signed [63:0] ft, fn, dt, dn, tt, nn, px, py, mom;
		angle_to_cos_sin(e[2], c, s);
		dx = clamp(64'(e[3]) - 64'(e[0]));
		dy = clamp(64'(e[4]) - 64'(e[1]));
		dvx = clamp(64'(e[8]) - 64'(e[5]));
		dvy = clamp(64'(e[9]) - 64'(e[6]));
		td = fx_dot(c, dx, s, dy);
		nd = fx_dot(-s, dx, c, dy);
		tv = fx_dot(c, dvx, s, dvy);
		nv = fx_dot(-s, dvx, c, dvy);
		ft = fx_mul(fx_mul(axial_k, clamp(td - len0)), inv_len);
		fn = fx_mul(fx_mul(shear_k, nd), inv_len);
		dt = clamp(2 * fx_mul(damp_t, fx_mul(tv, inv_len)));
		dn = clamp(2 * fx_mul(damp_n, clamp(fx_mul(nv, inv_len) - 64'(e[7]))));
		tt = clamp(ft + dt);
		nn = clamp(fn + dn);
		px = fx_dot(c, tt, -s, nn);
		py = fx_dot(s, tt, c, nn);
		mom = clamp(-fx_mul(nd, ft) + fx_mul(td, fn) + fx_mul(len0, dn));
		f[31:0] = 32'(clamp(px + hw_x));
		f[63:32] = 32'(clamp(py + hw_y));
		f[95:64] = 32'(mom);
		f[127:96] = 32'(clamp(-px + hw_x));
		f[159:128] = 32'(clamp(-py + hw_y));
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		err_count++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_AXIAL_STIFFNESS: axial_k = {33'd0, v[30:0]};
			REG_SHEAR_STIFFNESS: shear_k = {33'd0, v[30:0]};
			REG_ELEMENT_LENGTH: len0 = {33'd0, v[30:0]};
			REG_INVERSE_LENGTH: inv_len = {33'd0, v[30:0]};
			REG_HALF_WEIGHT_X: hw_x = 64'($signed(v));
			REG_HALF_WEIGHT_Y: hw_y = 64'($signed(v));
			REG_DAMPING_AXIAL: damp_t = {33'd0, v[30:0]};
			default: damp_n = {33'd0, v[30:0]};
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (force_queue.size() != 0) @(posedge clk);
		repeat (Latency + 5) @(posedge clk);
	endtask

	task automatic send_element(input elem_t e);
		logic [159:0] f;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		for (int i = 0; i < 10; i++)
			s_tdata[32*i +: 32] <= e[i];
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_forces(e, f);
		force_queue.push_back(f);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(65536 * 8)) - 262144);
			3: return $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic elem_t rand_element();
		elem_t e;
		for (int i = 0; i < 10; i++)
			e[i] = ($urandom_range(3) == 0) ? rand_word()
				: 32'($signed($urandom_range(65536 * 40)) - 1310720);
		return e;
	endfunction

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		logic [159:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (force_queue.size() == 0) begin
				$display("unexpected output %h", m_tdata);
				err_count++;
			end else begin
				want = force_queue.pop_front();
				if (m_tdata[31:0] !== want[31:0])
					report_mismatch("force_a_x", m_tdata[31:0], want[31:0]);
				if (m_tdata[63:32] !== want[63:32])
					report_mismatch("force_a_y", m_tdata[63:32], want[63:32]);
				if (m_tdata[95:64] !== want[95:64])
					report_mismatch("moment_angle", m_tdata[95:64], want[95:64]);
				if (m_tdata[127:96] !== want[127:96])
					report_mismatch("force_b_x", m_tdata[127:96], want[127:96]);
				if (m_tdata[159:128] !== want[159:128])
					report_mismatch("force_b_y", m_tdata[159:128], want[159:128]);
			end
		end
	end

	task automatic test_directed();
		elem_t e;
		for (int k = 0; k < 20; k++) begin
			foreach (e[i])
				e[i] = '0;
			case (k)
				0: ;
				1: e[3] = 32'h0001_0000;
				2: begin e[2] = 32'h0001_921f; e[4] = 32'h0002_0000; end
				3: e[2] = 32'h7fff_ffff;
				4: e[2] = 32'h8000_0000;
				5: begin e[0] = 32'h8000_0000; e[3] = 32'h7fff_ffff; end
				6: begin e[1] = 32'h7fff_ffff; e[4] = 32'h8000_0000; end
				7: begin e[5] = 32'h8000_0000; e[8] = 32'h7fff_ffff; e[7] = 32'h7fff_ffff; end
				8: begin e[6] = 32'h7fff_ffff; e[9] = 32'h8000_0000; e[7] = 32'h8000_0000; end
				9: foreach (e[i]) e[i] = 32'hffff_ffff;
				10: foreach (e[i]) e[i] = 32'h7fff_ffff;
				11: foreach (e[i]) e[i] = 32'h8000_0000;
				12: begin e[2] = 32'hfffe_6de1; e[3] = 32'h0003_0000; e[9] = 32'h0001_0000; end
				default: e = rand_element();
			endcase
			send_element(e);
		end
	endtask

	task automatic test_random(input int n);
		repeat (n) send_element(rand_element());
	endtask

	task automatic test_config_sweep();
		write_reg(REG_AXIAL_STIFFNESS, 32'h7fff_ffff);
		write_reg(REG_SHEAR_STIFFNESS, 32'h0000_0000);
		write_reg(REG_ELEMENT_LENGTH, 32'h7fff_ffff);
		write_reg(REG_INVERSE_LENGTH, 32'h0000_0001);
		write_reg(REG_HALF_WEIGHT_X, 32'h8000_0000);
		write_reg(REG_HALF_WEIGHT_Y, 32'h7fff_ffff);
		write_reg(REG_DAMPING_AXIAL, 32'h7fff_ffff);
		write_reg(REG_DAMPING_SHEAR, 32'hffff_ffff);
		test_directed();
		test_random(100);
		drain();
		write_reg(REG_SHEAR_STIFFNESS, 32'h7fff_ffff);
		write_reg(REG_ELEMENT_LENGTH, 32'h0000_0000);
		write_reg(REG_INVERSE_LENGTH, 32'h7fff_ffff);
		write_reg(REG_AXIAL_STIFFNESS, 32'h0000_0000);
		write_reg(REG_DAMPING_AXIAL, 32'h0000_0000);
		write_reg(REG_DAMPING_SHEAR, 32'h0000_0000);
		test_random(100);
		drain();
	endtask

	task automatic test_stall_fill();
		hold_cycles = 200;
		test_random(80);
		drain();
	endtask

	task automatic test_random_configs();
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 19 : (p == 1) ? 74 : 0;
			recv_idle_pct = (p == 0) ? 74 : (p == 1) ? 19 : 0;
			write_reg(REG_AXIAL_STIFFNESS, $urandom_range(65536 * 50));
			write_reg(REG_SHEAR_STIFFNESS, $urandom_range(65536 * 50));
			write_reg(REG_ELEMENT_LENGTH, $urandom_range(1, 65536 * 4));
			write_reg(REG_INVERSE_LENGTH, $urandom_range(1, 65536 * 4));
			write_reg(REG_HALF_WEIGHT_X, rand_word());
			write_reg(REG_HALF_WEIGHT_Y, $urandom);
			write_reg(REG_DAMPING_AXIAL, $urandom_range(65536 * 8));
			write_reg(REG_DAMPING_SHEAR, $urandom);
			test_random(300);
			drain();
		end
	endtask

	initial begin
		axial_k = 65536; shear_k = 65536; len0 = 65536; inv_len = 65536;
		hw_x = 0; hw_y = 0; damp_t = 0; damp_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 19;
		recv_idle_pct = 74;
		test_directed();
		drain();
		test_config_sweep();
		test_stall_fill();
		test_random_configs();
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
